// File: rtl/assert_macros.svh
// Assertion macros used by the segment_fit_allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define SFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset
`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg: shared types and constants
// Types, sizes and codes of the segment fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package sfa_pkg;
    localparam int MemWords    = 1024;
    localparam int Processes   = 6;
    localparam int SegsPerProc = 10;
    localparam int HoleSlots   = 64;
    localparam int AW = $clog2(MemWords);
    localparam int SW = $clog2(MemWords + 1);
    localparam int PW = $clog2(Processes + 1);
    localparam int CW = $clog2(SegsPerProc + 1);
    localparam int HW = $clog2(HoleSlots);
    localparam int SegSlots = Processes * SegsPerProc;
    localparam int GW = $clog2(SegSlots);

    localparam logic [1:0] ST_ALLOCATED  = 2'd0;
    localparam logic [1:0] ST_NO_FIT     = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_FREED      = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic          operation;
        logic [PW-1:0] process_id;
        logic [SW-1:0] alloc_size;
    } t_req;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] alloc_base;
        logic [SW-1:0] free_total;
    } t_rsp;

    // Hole entry carried along the chain
    typedef struct packed {
        logic          valid;
        logic [AW-1:0] base;
        logic [SW-1:0] size;
    } t_hole;

    // Candidate travelling with the scan
    typedef struct packed {
        logic          found;
        logic [HW-1:0] idx;
        logic [AW-1:0] base;
        logic [SW-1:0] size;
    } t_cand;

    // Command from controller to the cell chain
    typedef struct packed {
        logic          shift;   // rotate all cells by one place
        logic          pick;    // evaluate candidate on head cell
        logic          merge;   // match freed range against head cell
        logic          write;   // overwrite head cell with wdata
        t_hole         wdata;
    } t_ctl;
endpackage
`default_nettype wire

// File: rtl/segment_fit_allocator.sv
// Segment fit allocator: hole table as a rotating ring of 64 cells.
// Allocate: a pick pass over the ring, an update pass and a done state, then the strobe;
// the next request can be taken in the strobe's cycle.
// Free: per segment a read, load, match pass and write pass, then a final read and load
// and the done state before the strobe; busy stays high throughout.
// Synchronous active-low reset restores one hole covering all memory; no output stall.
`default_nettype none
module segment_fit_allocator import sfa_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output      logic       busy,
    input  wire t_req       i_req,
    output      logic       o_rsp_valid,
    output      t_rsp       o_rsp,
    input  wire logic       i_cfg_valid,
    output      logic       o_cfg_ready,
    input  wire logic [1:0] i_cfg_data
);
`include "assert_macros.svh"

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_PICK  = 8'b00000010,
        S_APPLY = 8'b00000100,
        S_FRD   = 8'b00001000,
        S_FLOAD = 8'b00010000,
        S_FSCAN = 8'b00100000,
        S_FWRT  = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    t_state        r_state, n_state;
    logic [1:0]    r_policy;
    t_req          r_req;
    logic [HW:0]   r_cnt;
    t_cand         r_cand;
    logic [SW-1:0] r_free;
    t_rsp          r_rsp;
    logic          r_rsp_valid;
    logic [CW-1:0] r_segcnt [Processes];
    logic [CW-1:0] r_k;
    logic [AW-1:0] r_fbase;
    logic [SW-1:0] r_flen;
    logic          r_below, r_above, r_spare;
    logic [HW-1:0] r_bidx, r_aidx, r_sidx;
    logic [SW-1:0] r_asize;
    logic [AW-1:0] r_seg_base [SegSlots];
    logic [SW-1:0] r_seg_len  [SegSlots];
    logic [AW-1:0] r_rd_base;
    logic [SW-1:0] r_rd_len;

    t_ctl          w_ctl;
    t_hole         w_head;
    logic [HW-1:0] w_pos;
    logic          w_pid_ok;
    logic [PW-1:0] w_p;
    logic [CW-1:0] w_cnt_p;
    logic          w_fits, w_better, w_take;
    logic [GW-1:0] w_slot;
    logic [AW-1:0] w_end;
    logic          w_last;

    sfa_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_head  (w_head)
    );

    assign w_pos    = r_cnt[HW-1:0];
    assign w_last   = (r_cnt == (HW+1)'(HoleSlots - 1));
    assign w_pid_ok = (r_req.process_id >= PW'(1)) && (r_req.process_id <= PW'(Processes));
    assign w_p      = w_pid_ok ? PW'(r_req.process_id - PW'(1)) : '0;
    assign w_cnt_p  = r_segcnt[w_p];
    assign w_slot   = GW'(w_p * SegsPerProc) + GW'(r_k);
    assign w_end    = AW'(w_head.base + w_head.size[AW-1:0]);

    // Candidate test on the head cell
    always_comb begin
        w_fits   = w_head.valid && (w_head.size >= r_req.alloc_size);
        w_better = 1'b0;
        case (r_policy)
            POL_FIRST: w_better = w_head.base < r_cand.base;
            POL_BEST:  w_better = (w_head.size < r_cand.size) ||
                                  (w_head.size == r_cand.size && w_head.base < r_cand.base);
            POL_WORST: w_better = (w_head.size > r_cand.size) ||
                                  (w_head.size == r_cand.size && w_head.base < r_cand.base);
            default:   w_better = 1'b0;
        endcase
        w_take = w_fits && (!r_cand.found || w_better);
    end

    // Ring commands per state
    always_comb begin
        w_ctl       = '0;
        w_ctl.wdata = w_head;
        case (r_state)
            S_PICK:  w_ctl.shift = 1'b1;
            S_APPLY: begin
                w_ctl.shift = 1'b1;
                if (r_cand.found && w_pos == r_cand.idx) begin
                    w_ctl.write = 1'b1;
                    if (w_head.size == r_req.alloc_size) begin
                        w_ctl.wdata.valid = 1'b0;
                    end else begin
                        w_ctl.wdata.base = AW'(w_head.base + r_req.alloc_size[AW-1:0]);
                        w_ctl.wdata.size = w_head.size - r_req.alloc_size;
                    end
                end
            end
            S_FSCAN: w_ctl.shift = 1'b1;
            S_FWRT:  begin
                w_ctl.shift = 1'b1;
                if (r_below && w_pos == r_bidx) begin
                    w_ctl.write      = 1'b1;
                    w_ctl.wdata.size = w_head.size + r_flen + (r_above ? r_asize : '0);
                end else if (r_below && r_above && w_pos == r_aidx) begin
                    w_ctl.write       = 1'b1;
                    w_ctl.wdata.valid = 1'b0;
                end else if (!r_below && r_above && w_pos == r_aidx) begin
                    w_ctl.write      = 1'b1;
                    w_ctl.wdata.base = r_fbase;
                    w_ctl.wdata.size = w_head.size + r_flen;
                end else if (!r_below && !r_above && r_spare && w_pos == r_sidx) begin
                    w_ctl.write       = 1'b1;
                    w_ctl.wdata.valid = 1'b1;
                    w_ctl.wdata.base  = r_fbase;
                    w_ctl.wdata.size  = r_flen;
                end
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) begin
                n_state = (i_req.operation == OP_FREE) ? S_FRD : S_PICK;
            end
            S_PICK: if (w_last) begin
                n_state = S_APPLY;
            end
            S_APPLY: if (w_last) begin
                n_state = S_DONE;
            end
            S_FRD:   n_state = S_FLOAD;
            S_FLOAD: n_state = (!w_pid_ok || r_k >= w_cnt_p || r_k >= CW'(SegsPerProc))
                               ? S_DONE : S_FSCAN;
            S_FSCAN: if (w_last) begin
                n_state = S_FWRT;
            end
            S_FWRT: if (w_last) begin
                n_state = S_FRD;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Segment table memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY && w_last && r_cand.found && r_rsp.status == ST_ALLOCATED) begin
            r_seg_base[GW'(w_p * SegsPerProc) + GW'(w_cnt_p)] <= r_cand.base;
            r_seg_len[GW'(w_p * SegsPerProc) + GW'(w_cnt_p)]  <= r_req.alloc_size;
        end
        r_rd_base <= r_seg_base[w_slot];
        r_rd_len  <= r_seg_len[w_slot];
    end

    // Control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= POL_FIRST;
            r_free      <= SW'(MemWords);
            r_rsp_valid <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
            for (int i = 0; i < Processes; i++) begin
                r_segcnt[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_policy <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: if (start) begin
                    r_req       <= i_req;
                    r_cnt       <= '0;
                    r_k         <= '0;
                    r_cand      <= '0;
                    r_rsp       <= '0;
                end
                S_PICK: begin
                    r_cnt <= w_last ? '0 : r_cnt + 1'b1;
                    // Decide outcome on the last slot, before the update pass
                    if (w_last && (!w_pid_ok || w_cnt_p >= CW'(SegsPerProc))) begin
                        r_rsp.status <= ST_TABLE_FULL;
                        r_cand.found <= 1'b0;
                    end else if (w_last && (r_req.alloc_size == '0 || r_policy > POL_WORST ||
                                            !(r_cand.found || w_take))) begin
                        r_rsp.status <= ST_NO_FIT;
                        r_cand.found <= 1'b0;
                    end else begin
                        if (w_take) begin
                            r_cand <= '{found: 1'b1, idx: w_pos, base: w_head.base,
                                        size: w_head.size};
                        end
                        if (w_last) begin
                            r_rsp.status <= ST_ALLOCATED;
                        end
                    end
                end
                S_APPLY: begin
                    r_cnt <= w_last ? '0 : r_cnt + 1'b1;
                    if (w_last && r_cand.found && r_rsp.status == ST_ALLOCATED) begin
                        r_segcnt[w_p]    <= w_cnt_p + 1'b1;
                        r_free           <= r_free - r_req.alloc_size;
                        r_rsp.alloc_base <= r_cand.base;
                    end
                end
                S_FLOAD: begin
                    r_rsp.status <= ST_FREED;
                    r_fbase      <= r_rd_base;
                    r_flen       <= r_rd_len;
                    r_below      <= 1'b0;
                    r_above      <= 1'b0;
                    r_spare      <= 1'b0;
                    r_cnt        <= '0;
                    if (w_pid_ok && (r_k >= w_cnt_p || r_k >= CW'(SegsPerProc))) begin
                        r_segcnt[w_p] <= '0;
                    end
                end
                S_FSCAN: begin
                    r_cnt <= w_last ? '0 : r_cnt + 1'b1;
                    if (!w_head.valid) begin
                        if (!r_spare) begin
                            r_spare <= 1'b1;
                            r_sidx  <= w_pos;
                        end
                    end else begin
                        if (w_end == r_fbase && (w_head.base + w_head.size) != SW'(0)
                            && SW'(w_head.base) + w_head.size == SW'(r_fbase)) begin
                            r_below <= 1'b1;
                            r_bidx  <= w_pos;
                        end
                        if (SW'(w_head.base) == SW'(r_fbase) + r_flen) begin
                            r_above <= 1'b1;
                            r_aidx  <= w_pos;
                            r_asize <= w_head.size;
                        end
                    end
                end
                S_FWRT: begin
                    r_cnt <= w_last ? '0 : r_cnt + 1'b1;
                    if (w_last) begin
                        r_k <= r_k + 1'b1;
                        if (r_below || r_above || r_spare) begin
                            r_free <= r_free + r_flen;
                        end
                    end
                end
                S_DONE: begin
                    r_rsp_valid       <= 1'b1;
                    r_rsp.free_total  <= r_free;
                end
                default: ;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `SFA_ASSERT_IMPL(a_rsp_idle, i_clk, i_rst_n, r_rsp_valid, r_state == S_IDLE)
    `SFA_ASSERT_NEXT(a_done_rsp, i_clk, i_rst_n, r_state == S_DONE, r_rsp_valid)
    `SFA_ASSERT_IMPL(a_free_cap, i_clk, i_rst_n, 1'b1, r_free <= SW'(MemWords))
endmodule
`default_nettype wire

// File: rtl/sfa_cell.sv
// ----------------------------------------------------------------------------
// sfa_cell: one hole slot of the ring
// Holds one hole entry and hands it to its neighbour on every shift.
// ----------------------------------------------------------------------------
`default_nettype none
module sfa_cell import sfa_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_shift,
    input  wire logic  i_load,
    input  wire t_hole i_load_val,
    input  wire t_hole i_rst_val,
    input  wire t_hole i_prev,
    output      t_hole o_hole
);
    t_hole r_hole;
    // Reset, load, take neighbour's word, or hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hole <= i_rst_val;
        end else if (i_load) begin
            r_hole <= i_load_val;
        end else if (i_shift) begin
            r_hole <= i_prev;
        end
    end
    assign o_hole = r_hole;
endmodule
`default_nettype wire

// File: rtl/sfa_ring.sv
// ----------------------------------------------------------------------------
// sfa_ring: ring of hole cells
// Rotates hole entries past the head cell, where the controller looks.
// ----------------------------------------------------------------------------
`default_nettype none
module sfa_ring import sfa_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_ctl  i_ctl,
    output      t_hole o_head
);
    t_hole w_h [HoleSlots];
    genvar g;
    // Cell g takes from cell g+1; head is cell 0, which passes to the tail
    for (g = 0; g < HoleSlots; g++) begin : g_cell
        t_hole w_rst;
        t_hole w_prev;
        assign w_rst.valid = (g == 0);
        assign w_rst.base  = '0;
        assign w_rst.size  = (g == 0) ? SW'(MemWords) : '0;
        if (g == HoleSlots - 1) begin : g_tail
            // head leaves with its written value when write and shift coincide
            assign w_prev = i_ctl.write ? i_ctl.wdata : w_h[0];
        end else begin : g_mid
            assign w_prev = w_h[g+1];
        end
        sfa_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (i_ctl.shift),
            .i_load     (g == 0 && i_ctl.write && !i_ctl.shift),
            .i_load_val (i_ctl.wdata),
            .i_rst_val  (w_rst),
            .i_prev     (w_prev),
            .o_hole     (w_h[g])
        );
    end
    assign o_head = w_h[0];
endmodule
`default_nettype wire
